### src/sida_pkg.sv
// Shared types, constants and the double-dabble step for the decimal text converter.
`timescale 1ns / 1ps

package sida_pkg;

  localparam int unsigned BinWidth      = 32;
  localparam int unsigned NumDigits     = 10;
  localparam int unsigned DigitWidth    = 4;
  localparam int unsigned BcdWidth      = NumDigits * DigitWidth;
  localparam int unsigned DdStages      = 8;
  localparam int unsigned StepsPerStage = BinWidth / DdStages;
  localparam int unsigned IdxWidth      = $clog2(NumDigits);

  localparam logic [7:0] AsciiZero  = 8'd48;
  localparam logic [7:0] AsciiMinus = 8'd45;

  typedef logic [NumDigits-1:0][DigitWidth-1:0] bcd_t;

  typedef struct packed {
    logic                neg;
    bcd_t                bcd;
    logic [BinWidth-1:0] bin;
  } dd_t;

  // One shift-add-3 iteration: correct every digit, then shift the whole word left.
  function automatic dd_t dd_step(input dd_t d);
    dd_t  r;
    bcd_t adj;
    r   = d;
    adj = d.bcd;
    for (int i = 0; i < NumDigits; i++) begin
      if (adj[i] >= 4'd5) begin
        adj[i] = adj[i] + 4'd3;
      end
    end
    {r.bcd, r.bin} = {adj[NumDigits-1:0], d.bin} << 1;
    return r;
  endfunction

  function automatic dd_t dd_stage(input dd_t d);
    dd_t r;
    r = d;
    for (int s = 0; s < StepsPerStage; s++) begin
      r = dd_step(r);
    end
    return r;
  endfunction

endpackage

### src/signed_int_to_decimal_ascii.sv
// Signed 32-bit integer to decimal ASCII character stream, pipelined double dabble.
// Pipeline: one magnitude stage, then eight double-dabble stages of four steps
//   each, then the serializer.
// Throughput: a new request may enter every cycle while in_ready is high; the output port
//   sends one character a cycle when out_ready is high, 1 to 11 per number (sign, digits).
// Reset: rst clears all pipeline valid bits and the serializer; data registers are not reset.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii
  import sida_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [31:0]  value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          char_code,
  output logic                last_char
);

  // stage 0 holds the magnitude, stages 1..DdStages run the conversion
  logic [DdStages:0]   v;
  dd_t                 st [DdStages+1];
  logic [DdStages+1:0] rdy;

  logic                ser_valid;
  logic                ser_neg;
  bcd_t                ser_bcd;
  logic [IdxWidth-1:0] ser_idx;
  logic [IdxWidth-1:0] top_idx;
  logic                out_fire;
  logic                ser_load;
  logic [BinWidth-1:0] mag;

  assign out_fire = out_valid && out_ready;
  assign ser_load = v[DdStages] && rdy[DdStages+1];

  always_comb begin
    rdy[DdStages+1] = !ser_valid || (out_fire && last_char);
    for (int k = DdStages; k >= 0; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
  end

  assign in_ready = rdy[0];
  assign mag      = value[BinWidth-1] ? (BinWidth'(0) - BinWidth'(value)) : BinWidth'(value);

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) begin
        v[0] <= in_valid;
      end
      for (int k = 1; k <= DdStages; k++) begin
        if (rdy[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      st[0].neg <= value[BinWidth-1];
      st[0].bcd <= '0;
      st[0].bin <= mag;
    end
    for (int k = 1; k <= DdStages; k++) begin
      if (rdy[k]) begin
        st[k] <= dd_stage(st[k-1]);
      end
    end
  end

  // most significant nonzero digit, zero gives index 0
  always_comb begin
    top_idx = '0;
    for (int i = 0; i < NumDigits; i++) begin
      if (st[DdStages].bcd[i] != '0) begin
        top_idx = IdxWidth'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ser_valid <= 1'b0;
      ser_neg   <= 1'b0;
    end else if (ser_load) begin
      ser_valid <= 1'b1;
      ser_neg   <= st[DdStages].neg;
    end else if (out_fire) begin
      if (ser_neg) begin
        ser_neg <= 1'b0;
      end else if (ser_idx == '0) begin
        ser_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ser_load) begin
      ser_bcd <= st[DdStages].bcd;
      ser_idx <= top_idx;
    end else if (out_fire && !ser_neg && ser_idx != '0) begin
      ser_idx <= ser_idx - 1'b1;
    end
  end

  assign out_valid = ser_valid;
  assign char_code = ser_neg ? AsciiMinus : (AsciiZero + 8'(ser_bcd[ser_idx]));
  assign last_char = !ser_neg && (ser_idx == '0);

`ifndef SYNTHESIS
  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    (ser_valid && !ser_neg) |-> (char_code >= AsciiZero && char_code <= AsciiZero + 8'd9))
    else $error("digit character out of range");

  a_no_leading_zero: assert property (@(posedge clk) disable iff (rst)
    ser_load |=> (ser_idx == '0 || ser_bcd[ser_idx] != '0))
    else $error("leading zero digit loaded");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (v[DdStages] && !rdy[DdStages+1]) |=> (v[DdStages] && $stable(st[DdStages])))
    else $error("last conversion stage changed while stalled");

  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    (out_fire && last_char && !ser_load) |=> !ser_valid)
    else $error("serializer still busy after last character");
`endif

endmodule
